/* src/wmbh_pkg.sv */
// shared constants and pipeline token types for the byte hash
`timescale 1ns / 1ps
package wmbh_pkg;

  localparam logic [63:0] HASH_SEED  = 64'd5381;
  localparam logic [31:0] HASH_PRIME = 32'd2546270801;
  localparam int unsigned HASH_SHIFT = 45;

  typedef struct packed {
    logic        fin;
    logic        mix;
    logic        long_msg;
    logic [3:0]  fill;
    logic [63:0] win;
    logic [63:0] x;
  } s1_t;

  typedef struct packed {
    logic        fin;
    logic        mix;
    logic        long_msg;
    logic [3:0]  fill;
    logic [63:0] win;
    logic [63:0] lo;
    logic [31:0] xh;
  } s2_t;

  typedef struct packed {
    logic        long_msg;
    logic [3:0]  fill;
    logic [63:0] win;
    logic [63:0] h;
  } fin_t;

endpackage

/* src/word_multiply_byte_hash.sv */
// top level of the streaming 64-bit word multiply byte hash
// usage:
//   in_ channel: one byte per item, a message byte in in_data_byte, in_last
//   closing the message, in_no_byte marking an item without a byte (with
//   in_last it closes an empty or already complete message)
//   out_ channel: one out_digest for every item that carries in_last
//   an item is taken on a rising edge with valid high and stall low
// throughput: one item per cycle while in_stall is low; the 64 by 32 bit mix is split
//   into two 32 bit products over two pipeline stages
// path: the closing item passes the s1, s2 and s3 registers and then the output
//   register before out_valid rises
// reset: rst_n low for a cycle clears the pipeline and restarts the hash at
//   its seed with an empty byte window
// receiver stall: a waiting digest sits in the output register while items
//   keep flowing; only when a second digest reaches the last stage behind it
//   does the whole pipeline hold and in_stall rise
`timescale 1ns / 1ps
module word_multiply_byte_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last,
  input  logic        in_no_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_digest
);

  logic           adv;
  logic [63:0]    h;
  logic           s1_v, s3_v;
  wmbh_pkg::s1_t  s1;
  wmbh_pkg::fin_t s3;

  wmbh_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_last      (in_last),
    .in_no_byte   (in_no_byte),
    .h            (h),
    .s1_v         (s1_v),
    .s1           (s1)
  );

  wmbh_mix u_mix (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .s1_v  (s1_v),
    .s1    (s1),
    .h     (h),
    .s3_v  (s3_v),
    .s3    (s3)
  );

  wmbh_final u_final (
    .clk        (clk),
    .rst_n      (rst_n),
    .s3_v       (s3_v),
    .s3         (s3),
    .out_stall  (out_stall),
    .adv        (adv),
    .out_valid  (out_valid),
    .out_digest (out_digest)
  );

  assign in_stall = !adv;

endmodule

/* src/wmbh_front.sv */
// byte window, fill count and mix operand capture at input acceptance
`timescale 1ns / 1ps
module wmbh_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [7:0]          in_data_byte,
  input  logic                in_last,
  input  logic                in_no_byte,
  input  logic [63:0]         h,
  output logic                s1_v,
  output wmbh_pkg::s1_t       s1
);

  logic [63:0]   win_r, win_nxt, win_upd;
  logic [3:0]    fill_r, fill_nxt, fill_upd, fill_base;
  logic          long_r, long_nxt, long_upd;
  logic          s1_v_r;
  wmbh_pkg::s1_t s1_r, tok;
  logic          accept, byte_ok, mix;

  assign accept = in_valid && adv;

  always_comb begin
    byte_ok   = !in_no_byte;
    mix       = byte_ok && fill_r[3];
    fill_base = mix ? 4'd0 : fill_r;
    win_upd   = byte_ok ? {in_data_byte, win_r[63:8]} : win_r;
    fill_upd  = byte_ok ? fill_base + 4'd1 : fill_r;
    long_upd  = long_r | (byte_ok & fill_upd[3]);

    tok.fin      = in_last;
    tok.mix      = mix;
    tok.long_msg = long_upd;
    tok.fill     = fill_upd;
    tok.win      = win_upd;
    tok.x        = h ^ (h >> wmbh_pkg::HASH_SHIFT) ^ win_r;

    win_nxt  = win_r;
    fill_nxt = fill_r;
    long_nxt = long_r;
    if (accept) begin
      if (in_last) begin
        win_nxt  = '0;
        fill_nxt = '0;
        long_nxt = 1'b0;
      end else begin
        win_nxt  = win_upd;
        fill_nxt = fill_upd;
        long_nxt = long_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      fill_r <= '0;
      long_r <= 1'b0;
      s1_v_r <= 1'b0;
    end else begin
      win_r  <= win_nxt;
      fill_r <= fill_nxt;
      long_r <= long_nxt;
      if (adv) begin
        s1_v_r <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= tok;
    end
  end

  assign s1_v = s1_v_r;
  assign s1   = s1_r;

`ifndef ASSERT_OFF
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n) fill_r <= 4'd8)
    else $error("fill count beyond one word");
  a_long_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    long_r |-> fill_r != 4'd0)
    else $error("long message with empty window");
`endif

endmodule

/* src/wmbh_mix.sv */
// two stage split multiply and running hash register
`timescale 1ns / 1ps
module wmbh_mix (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                s1_v,
  input  wmbh_pkg::s1_t       s1,
  output logic [63:0]         h,
  output logic                s3_v,
  output wmbh_pkg::fin_t      s3
);

  logic           s2_v_r, s3_v_r;
  wmbh_pkg::s2_t  s2_r, s2_nxt;
  wmbh_pkg::fin_t s3_r, s3_nxt;
  logic [63:0]    h_r, h_nxt, mixed, h_cur;
  logic [31:0]    hi_prod;

  always_comb begin
    s2_nxt.fin      = s1.fin;
    s2_nxt.mix      = s1.mix;
    s2_nxt.long_msg = s1.long_msg;
    s2_nxt.fill     = s1.fill;
    s2_nxt.win      = s1.win;
    s2_nxt.lo       = {32'd0, s1.x[31:0]} * {32'd0, wmbh_pkg::HASH_PRIME};
    s2_nxt.xh       = s1.x[63:32];
  end

  // upper half only needs the low 32 bits of its product
  assign hi_prod = s2_r.xh * wmbh_pkg::HASH_PRIME;
  assign mixed   = {s2_r.lo[63:32] + hi_prod, s2_r.lo[31:0]};
  assign h_cur   = s2_r.mix ? mixed : h_r;

  always_comb begin
    s3_nxt.long_msg = s2_r.long_msg;
    s3_nxt.fill     = s2_r.fill;
    s3_nxt.win      = s2_r.win;
    s3_nxt.h        = h_cur;
    h_nxt = h_r;
    if (adv && s2_v_r) begin
      h_nxt = s2_r.fin ? wmbh_pkg::HASH_SEED : h_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      h_r    <= wmbh_pkg::HASH_SEED;
    end else begin
      h_r <= h_nxt;
      if (adv) begin
        s2_v_r <= s1_v;
        s3_v_r <= s2_v_r && s2_r.fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
    end
  end

  assign h    = h_r;
  assign s3_v = s3_v_r;
  assign s3   = s3_r;

`ifndef ASSERT_OFF
  a_mix_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_v && s1.mix && s2_v_r && s2_r.mix))
    else $error("two mixes in flight at once");
`endif

endmodule

/* src/wmbh_final.sv */
// digest selection, output register and pipeline advance
`timescale 1ns / 1ps
module wmbh_final (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s3_v,
  input  wmbh_pkg::fin_t      s3,
  input  logic                out_stall,
  output logic                adv,
  output logic                out_valid,
  output logic [63:0]         out_digest
);

  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_digest_r, digest;
  logic [6:0]  sh;

  assign adv = !(s3_v && out_valid_r && out_stall);
  assign sh  = {4'd8 - s3.fill, 3'b000};

  always_comb begin
    if (s3.long_msg) begin
      digest = s3.h + s3.win;
    end else if (s3.fill == 4'd0) begin
      digest = '0;
    end else begin
      // short message bytes sit at the top of the window
      digest = s3.win >> sh;
    end
    out_valid_nxt = out_valid_r;
    if (s3_v && adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_v && adv) begin
      out_digest_r <= digest;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_digest = out_digest_r;

`ifndef ASSERT_OFF
  a_hold_final: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> s3_v && out_valid_r)
    else $error("held digest token lost");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_stall && !s3_v |=> !out_valid_r)
    else $error("taken digest not cleared");
`endif

endmodule
